// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define QVR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/qvr_pkg.sv =====
`timescale 1ns / 1ps

package qvr_pkg;

    // Vector coordinates and quaternion parts (Q2.14) are both 16-bit signed.
    localparam int unsigned W_COORD = 16;
    // q * v product and the sum of three of them (scale 2^14).
    localparam int unsigned W_PROD1 = 2 * W_COORD;
    localparam int unsigned W_TSUM  = W_PROD1 + 1;
    // t * conj(q) product and the biased sum of four of them (scale 2^28).
    localparam int unsigned W_PROD2 = W_TSUM + W_COORD;
    localparam int unsigned W_RSUM  = W_PROD2 + 2;
    // Fraction bits dropped by the final rounding.
    localparam int unsigned FRAC_TOTAL = 28;
    localparam int unsigned W_RND      = W_RSUM - FRAC_TOTAL;

    typedef logic signed [W_COORD-1:0] t_coord;
    typedef logic signed [W_PROD1-1:0] t_prod1;
    typedef logic signed [W_TSUM-1:0]  t_tsum;
    typedef logic signed [W_PROD2-1:0] t_prod2;
    typedef logic signed [W_RSUM-1:0]  t_rsum;
    typedef logic signed [W_RND-1:0]   t_rnd;

    // Half an output LSB, added before the floor to round to nearest.
    localparam t_rsum ROUND_BIAS = t_rsum'(1) <<< (FRAC_TOTAL - 1);

    localparam t_rnd COORD_MAX = t_rnd'(32767);
    localparam t_rnd COORD_MIN = -t_rnd'(32768);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ROT_X = 2'd0,
        REG_ROT_Y = 2'd1,
        REG_ROT_Z = 2'd2,
        REG_ROT_W = 2'd3
    } t_reg_idx;

    localparam t_coord ROT_W_RESET = t_coord'(16384);

endpackage

// ===== src/qvr_vec_in_if.sv =====
`timescale 1ns / 1ps

interface qvr_vec_in_if import qvr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vec_in_x;
    t_coord vec_in_y;
    t_coord vec_in_z;

    modport source (output valid, output vec_in_x, output vec_in_y, output vec_in_z,
                    input ready);
    modport sink   (input valid, input vec_in_x, input vec_in_y, input vec_in_z,
                    output ready);
endinterface

// ===== src/qvr_vec_out_if.sv =====
`timescale 1ns / 1ps

interface qvr_vec_out_if import qvr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vec_out_x;
    t_coord vec_out_y;
    t_coord vec_out_z;
    logic   clipped;

    modport source (output valid, output vec_out_x, output vec_out_y, output vec_out_z,
                    output clipped, input ready);
    modport sink   (input valid, input vec_out_x, input vec_out_y, input vec_out_z,
                    input clipped, output ready);
endinterface

// ===== src/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// Quaternion vector rotation: every vector v taken on i_vec is returned on o_vec as the
// vector part of q * v * conj(q), where q = (rot_x, rot_y, rot_z, rot_w) in Q2.14.
// q is not normalised, so the result carries a scale of |q|^2. The exact result is
// rounded to nearest (ties towards +infinity) once and saturated to 16 bits; clipped
// is raised when any coordinate saturated.
// Channels: i_vec and o_vec are valid/ready; a transaction happens on a rising edge
// with valid and ready both high. q is written through i_cfg_we/i_cfg_idx/i_cfg_data,
// one register per edge, and should only change while no vector is in flight.
// Pipeline: an accepted vector passes in order through the five register stages: the q*v
// products, t sums, t*conj(q) products, biased r sums, and round and saturate.
// Throughput: one vector per cycle while o_vec.ready holds the flow open; stages 1 to 4
// each hold one multiplier rank or one adder rank, and stage 5 the round and saturate.
// Stalls: every stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stalled receiver only holds the vectors already in flight;
// i_vec.ready is low only while every stage is full and o_vec.ready is low.
// Reset (synchronous, active low) empties the pipeline and loads the identity q.
`include "assert_macros.svh"

module quaternion_vector_rotate import qvr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_reg_idx              i_cfg_idx,
    input  logic [W_COORD-1:0]    i_cfg_data,
    qvr_vec_in_if.sink            i_vec,
    qvr_vec_out_if.source         o_vec
);

    // Quaternion registers.
    t_coord r_rot_x, r_rot_y, r_rot_z, r_rot_w;

    // Stage valid bits and advance enables.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic adv1, adv2, adv3, adv4, adv5;

    // Stage 1: the twelve q * v products.
    t_prod1 r_p1 [12];
    // Stage 2: t = q * v.
    t_tsum  r_tx, r_ty, r_tz, r_tw;
    // Stage 3: the twelve t * conj(q) products.
    t_prod2 r_p2 [12];
    // Stage 4: r = t * conj(q) with the rounding bias already added.
    t_rsum  r_rx, r_ry, r_rz;
    // Stage 5: rounded and saturated result.
    t_coord r_out_x, r_out_y, r_out_z;
    logic   r_clip;

    t_coord n_out_x, n_out_y, n_out_z;
    logic   n_clip;

    // A stage moves on when it is empty or when the stage after it moves on.
    assign adv5 = !r_v5 || o_vec.ready;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_vec.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x <= '0;
            r_rot_y <= '0;
            r_rot_z <= '0;
            r_rot_w <= ROT_W_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_X: r_rot_x <= t_coord'(i_cfg_data);
                REG_ROT_Y: r_rot_y <= t_coord'(i_cfg_data);
                REG_ROT_Z: r_rot_z <= t_coord'(i_cfg_data);
                REG_ROT_W: r_rot_w <= t_coord'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_vec.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
        end
    end

    // Stage 1 products, grouped by the t component that uses them.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p1[0]  <= t_prod1'(r_rot_w) * t_prod1'(i_vec.vec_in_x);
            r_p1[1]  <= t_prod1'(r_rot_y) * t_prod1'(i_vec.vec_in_z);
            r_p1[2]  <= t_prod1'(r_rot_z) * t_prod1'(i_vec.vec_in_y);
            r_p1[3]  <= t_prod1'(r_rot_w) * t_prod1'(i_vec.vec_in_y);
            r_p1[4]  <= t_prod1'(r_rot_z) * t_prod1'(i_vec.vec_in_x);
            r_p1[5]  <= t_prod1'(r_rot_x) * t_prod1'(i_vec.vec_in_z);
            r_p1[6]  <= t_prod1'(r_rot_w) * t_prod1'(i_vec.vec_in_z);
            r_p1[7]  <= t_prod1'(r_rot_x) * t_prod1'(i_vec.vec_in_y);
            r_p1[8]  <= t_prod1'(r_rot_y) * t_prod1'(i_vec.vec_in_x);
            r_p1[9]  <= t_prod1'(r_rot_x) * t_prod1'(i_vec.vec_in_x);
            r_p1[10] <= t_prod1'(r_rot_y) * t_prod1'(i_vec.vec_in_y);
            r_p1[11] <= t_prod1'(r_rot_z) * t_prod1'(i_vec.vec_in_z);
        end
    end

    // Stage 2: t = q * (v, 0). The scalar part is the negated dot product.
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_tx <= t_tsum'(r_p1[0]) + t_tsum'(r_p1[1]) - t_tsum'(r_p1[2]);
            r_ty <= t_tsum'(r_p1[3]) + t_tsum'(r_p1[4]) - t_tsum'(r_p1[5]);
            r_tz <= t_tsum'(r_p1[6]) + t_tsum'(r_p1[7]) - t_tsum'(r_p1[8]);
            r_tw <= -(t_tsum'(r_p1[9]) + t_tsum'(r_p1[10]) + t_tsum'(r_p1[11]));
        end
    end

    // Stage 3 products, grouped by the r component that uses them.
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_p2[0]  <= t_prod2'(r_tw) * t_prod2'(r_rot_x);
            r_p2[1]  <= t_prod2'(r_tx) * t_prod2'(r_rot_w);
            r_p2[2]  <= t_prod2'(r_ty) * t_prod2'(r_rot_z);
            r_p2[3]  <= t_prod2'(r_tz) * t_prod2'(r_rot_y);
            r_p2[4]  <= t_prod2'(r_tw) * t_prod2'(r_rot_y);
            r_p2[5]  <= t_prod2'(r_ty) * t_prod2'(r_rot_w);
            r_p2[6]  <= t_prod2'(r_tz) * t_prod2'(r_rot_x);
            r_p2[7]  <= t_prod2'(r_tx) * t_prod2'(r_rot_z);
            r_p2[8]  <= t_prod2'(r_tw) * t_prod2'(r_rot_z);
            r_p2[9]  <= t_prod2'(r_tz) * t_prod2'(r_rot_w);
            r_p2[10] <= t_prod2'(r_tx) * t_prod2'(r_rot_y);
            r_p2[11] <= t_prod2'(r_ty) * t_prod2'(r_rot_x);
        end
    end

    // Stage 4: r = t * conj(q), plus half an output LSB for the rounding.
    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_rx <= ROUND_BIAS - t_rsum'(r_p2[0]) + t_rsum'(r_p2[1])
                    - t_rsum'(r_p2[2]) + t_rsum'(r_p2[3]);
            r_ry <= ROUND_BIAS - t_rsum'(r_p2[4]) + t_rsum'(r_p2[5])
                    - t_rsum'(r_p2[6]) + t_rsum'(r_p2[7]);
            r_rz <= ROUND_BIAS - t_rsum'(r_p2[8]) + t_rsum'(r_p2[9])
                    - t_rsum'(r_p2[10]) + t_rsum'(r_p2[11]);
        end
    end

    // Dropping the fraction bits of the biased sum floors it; saturate afterwards.
    function automatic t_coord sat_coord(input t_rsum r, output logic clip);
        t_rnd fl;
        fl   = $signed(r[W_RSUM-1:FRAC_TOTAL]);
        clip = 1'b0;
        if (fl > COORD_MAX) begin
            clip = 1'b1;
            return t_coord'(COORD_MAX);
        end else if (fl < COORD_MIN) begin
            clip = 1'b1;
            return t_coord'(COORD_MIN);
        end
        return t_coord'(fl);
    endfunction

    always_comb begin
        logic cx, cy, cz;
        n_out_x = sat_coord(r_rx, cx);
        n_out_y = sat_coord(r_ry, cy);
        n_out_z = sat_coord(r_rz, cz);
        n_clip  = cx || cy || cz;
    end

    // Stage 5: output register.
    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            r_out_z <= n_out_z;
            r_clip  <= n_clip;
        end
    end

    assign o_vec.valid     = r_v5;
    assign o_vec.vec_out_x = r_out_x;
    assign o_vec.vec_out_y = r_out_y;
    assign o_vec.vec_out_z = r_out_z;
    assign o_vec.clipped   = r_clip;

    // Terms used by the checks below.
    logic in_accept, clip_out, out_at_bound, any_valid;

    assign in_accept    = i_vec.valid && i_vec.ready;
    assign clip_out     = o_vec.valid && o_vec.clipped;
    assign out_at_bound = (o_vec.vec_out_x == t_coord'(COORD_MAX))
                       || (o_vec.vec_out_x == t_coord'(COORD_MIN))
                       || (o_vec.vec_out_y == t_coord'(COORD_MAX))
                       || (o_vec.vec_out_y == t_coord'(COORD_MIN))
                       || (o_vec.vec_out_z == t_coord'(COORD_MAX))
                       || (o_vec.vec_out_z == t_coord'(COORD_MIN));
    assign any_valid    = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;

    // An accepted vector always lands in the first stage.
    `QVR_ASSERT(a_accept_loads, i_clk, i_rst_n, in_accept |=> r_v1, "accepted vector lost")

    // A clipped result must show at least one coordinate at a bound.
    `QVR_ASSERT(a_clip_at_bound, i_clk, i_rst_n, clip_out |-> out_at_bound, "clip with no bound")

    // Reset empties the pipeline.
    `QVR_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !any_valid, "busy after reset")

endmodule
